### hdl/mco_pkg.sv
package mco_pkg;

  // Chain capacity and stored dimension width
  localparam int MAX_MATRICES = 8;
  localparam int DIM_BITS     = 16;

  // Fixed port widths
  localparam int DIM_PORT_W = 16;
  localparam int ROW_W      = 4;
  localparam int SPLIT_W    = 4;
  localparam int STATUS_W   = 2;
  localparam int COST_W     = 51;

  localparam int MAX_DIMS  = MAX_MATRICES + 1;
  localparam int IDX_W     = $clog2(MAX_MATRICES);
  localparam int DADDR_W   = $clog2(MAX_DIMS);
  localparam int CNT_W     = $clog2(MAX_DIMS + 1);
  localparam int TAB_DEPTH = MAX_MATRICES * MAX_MATRICES;
  localparam int TAB_AW    = $clog2(TAB_DEPTH);

  // Product widths through the two multiplier stages
  localparam int PROD1_W = 2 * DIM_BITS;
  localparam int SAT1_W  = (PROD1_W < COST_W) ? PROD1_W : COST_W;
  localparam int PROD2_W = SAT1_W + DIM_BITS;

  localparam logic [COST_W-1:0] COST_MAX = '1;

  localparam logic [STATUS_W-1:0] STATUS_OK       = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] STATUS_SHORT    = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = STATUS_W'(2);

  typedef enum logic [3:0] {
    S_IDLE,
    S_STATUS,
    S_LD_A,
    S_LD_B,
    S_LD_C,
    S_RUN,
    S_DRAIN,
    S_WRITE,
    S_EMIT_RD,
    S_EMIT_WAIT
  } state_t;

  // Row-major table address from 0-based row and column
  function automatic logic [TAB_AW-1:0] tab_addr(input logic [IDX_W-1:0] r,
                                                 input logic [IDX_W-1:0] c);
    return TAB_AW'(TAB_AW'(r) * TAB_AW'(MAX_MATRICES)) + TAB_AW'(c);
  endfunction

endpackage

### hdl/mco_ram.sv
module mco_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/matrix_chain_order_core.sv
// Channel  Handshake            Payload
// in       in_valid / in_ready  dimension, last
// out      out_valid/out_ready  row, col, cost, split, status, end_of_run
//
// A dimension without last is taken while idle and the block stays idle.
// After the last dimension the block is busy: for each subchain it loads
// the two outer dimensions, issues one table read per split candidate into
// a five-stage cost pipeline, lets it drain and writes the minimum; then it
// reads and emits the results row by row. A status result goes out directly.
// Synchronous reset clears the sequencer, dimension count and output valid.
// A stalled output holds its result; the sequencer waits on it.
module matrix_chain_order_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mco_pkg::DIM_PORT_W-1:0] dimension,
  input  logic                          last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mco_pkg::ROW_W-1:0]     row,
  output logic [mco_pkg::ROW_W-1:0]     col,
  output logic [mco_pkg::COST_W-1:0]    cost,
  output logic [mco_pkg::SPLIT_W-1:0]   split,
  output logic [mco_pkg::STATUS_W-1:0]  status,
  output logic                          end_of_run
);
  import mco_pkg::*;

  state_t state, state_next;

  logic [CNT_W-1:0]    count;
  logic                overflow;
  logic [IDX_W-1:0]    mats0;
  logic [IDX_W-1:0]    i0, j0, kc;
  logic [DIM_BITS-1:0] p_a, p_b;
  logic [STATUS_W-1:0] stat_code;

  logic                in_acc, out_free;
  logic                count_room, ovf_eff, short_chain;
  logic [CNT_W-1:0]    n_eff;
  logic [IDX_W-1:0]    mats0_new;

  // sequencer strobes
  logic                dim_rd_en, cost_rd_en, split_rd_en, tab_we, issue;
  logic                load_status, load_emit;
  logic [DADDR_W-1:0]  dim_rd_addr;
  logic [TAB_AW-1:0]   cost_a_addr, cost_b_addr, tab_wr_addr;

  logic [DIM_BITS-1:0] dim_q;
  logic [COST_W-1:0]   cost_a_q, cost_b_q;
  logic [IDX_W-1:0]    split_q;

  // cost pipeline
  logic                v0, v1, v2, v3;
  logic [IDX_W-1:0]    k0r, k1, k2, k3;
  logic                zi0, zj0;
  logic [COST_W-1:0]   cm_a, cm_b;
  logic [PROD1_W-1:0]  prod1;
  logic [SAT1_W-1:0]   sat1;
  logic [PROD2_W-1:0]  prod2;
  logic [COST_W-1:0]   sat2;
  logic [COST_W:0]     csum1, csum2;
  logic [COST_W+1:0]   sum3;
  logic [COST_W-1:0]   q3, q_next;
  logic [COST_W-1:0]   best;
  logic [IDX_W-1:0]    best_k;
  logic                have;
  logic                diag;

  assign in_acc      = in_valid && in_ready;
  assign out_free    = !out_valid || out_ready;
  assign count_room  = count < CNT_W'(MAX_DIMS);
  assign n_eff       = count_room ? count + CNT_W'(1) : count;
  assign ovf_eff     = overflow || !count_room;
  assign short_chain = n_eff < CNT_W'(2);
  assign mats0_new   = IDX_W'(n_eff - CNT_W'(2));
  assign tab_wr_addr = tab_addr(i0, j0);
  assign cost_b_addr = tab_addr(IDX_W'(kc + 1), j0);
  assign diag        = (i0 == j0);

  mco_ram #(.WIDTH(DIM_BITS), .DEPTH(MAX_DIMS)) u_dim_ram (
    .clk     (clk),
    .wr_en   (in_acc && count_room),
    .wr_addr (count[DADDR_W-1:0]),
    .wr_data (DIM_BITS'(dimension)),
    .rd_en   (dim_rd_en),
    .rd_addr (dim_rd_addr),
    .rd_data (dim_q)
  );

  // Two copies of the cost table give both operand reads in the same cycle
  mco_ram #(.WIDTH(COST_W), .DEPTH(TAB_DEPTH)) u_cost_a_ram (
    .clk     (clk),
    .wr_en   (tab_we),
    .wr_addr (tab_wr_addr),
    .wr_data (best),
    .rd_en   (cost_rd_en),
    .rd_addr (cost_a_addr),
    .rd_data (cost_a_q)
  );

  mco_ram #(.WIDTH(COST_W), .DEPTH(TAB_DEPTH)) u_cost_b_ram (
    .clk     (clk),
    .wr_en   (tab_we),
    .wr_addr (tab_wr_addr),
    .wr_data (best),
    .rd_en   (cost_rd_en),
    .rd_addr (cost_b_addr),
    .rd_data (cost_b_q)
  );

  mco_ram #(.WIDTH(IDX_W), .DEPTH(TAB_DEPTH)) u_split_ram (
    .clk     (clk),
    .wr_en   (tab_we),
    .wr_addr (tab_wr_addr),
    .wr_data (best_k),
    .rd_en   (split_rd_en),
    .rd_addr (tab_wr_addr),
    .rd_data (split_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    dim_rd_en   = 1'b0;
    dim_rd_addr = DADDR_W'(kc) + DADDR_W'(1);
    cost_rd_en  = 1'b0;
    cost_a_addr = tab_addr(i0, j0);
    split_rd_en = 1'b0;
    tab_we      = 1'b0;
    issue       = 1'b0;
    load_status = 1'b0;
    load_emit   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && last) begin
          if (ovf_eff || short_chain) begin
            state_next = S_STATUS;
          end else if (mats0_new == '0) begin
            state_next = S_EMIT_RD;
          end else begin
            state_next = S_LD_A;
          end
        end
      end
      S_STATUS: begin
        if (out_free) begin
          load_status = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_LD_A: begin
        dim_rd_en   = 1'b1;
        dim_rd_addr = DADDR_W'(i0);
        state_next  = S_LD_B;
      end
      S_LD_B: begin
        dim_rd_en   = 1'b1;
        dim_rd_addr = DADDR_W'(j0) + DADDR_W'(1);
        state_next  = S_LD_C;
      end
      S_LD_C: begin
        state_next = S_RUN;
      end
      S_RUN: begin
        dim_rd_en   = 1'b1;
        cost_rd_en  = 1'b1;
        cost_a_addr = tab_addr(i0, kc);
        issue       = 1'b1;
        if (IDX_W'(kc + 1) == j0) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!(v0 || v1 || v2 || v3)) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        tab_we = 1'b1;
        if (j0 == mats0 && i0 == '0) begin
          state_next = S_EMIT_RD;
        end else begin
          state_next = S_LD_A;
        end
      end
      S_EMIT_RD: begin
        cost_rd_en  = 1'b1;
        split_rd_en = 1'b1;
        state_next  = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        if (out_free) begin
          load_emit = 1'b1;
          if (i0 == mats0 && j0 == mats0) begin
            state_next = S_IDLE;
          end else begin
            state_next = S_EMIT_RD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Chain collection
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
    end else if (in_acc) begin
      if (last) begin
        count    <= '0;
        overflow <= 1'b0;
      end else if (count_room) begin
        count <= count + CNT_W'(1);
      end else begin
        overflow <= 1'b1;
      end
    end
  end

  // Subchain walk: diagonal by diagonal during the DP, row-major on emission
  always_ff @(posedge clk) begin
    if (in_acc && last) begin
      mats0     <= mats0_new;
      stat_code <= ovf_eff ? STATUS_OVERFLOW : STATUS_SHORT;
      i0        <= '0;
      j0        <= (mats0_new == '0) ? IDX_W'(0) : IDX_W'(1);
    end else if (state == S_WRITE) begin
      if (j0 == mats0) begin
        if (i0 == '0) begin
          j0 <= '0;
        end else begin
          j0 <= IDX_W'(j0 - i0 + 1);
          i0 <= '0;
        end
      end else begin
        i0 <= i0 + IDX_W'(1);
        j0 <= j0 + IDX_W'(1);
      end
    end else if (load_emit) begin
      if (j0 == mats0) begin
        i0 <= i0 + IDX_W'(1);
        j0 <= i0 + IDX_W'(1);
      end else begin
        j0 <= j0 + IDX_W'(1);
      end
    end
    if (state == S_LD_A) begin
      kc <= i0;
    end else if (issue) begin
      kc <= kc + IDX_W'(1);
    end
    if (state == S_LD_B) begin
      p_a <= dim_q;
    end
    if (state == S_LD_C) begin
      p_b <= dim_q;
    end
  end

  // Diagonal entries are never written; their cost reads as zero
  assign cm_a = zi0 ? '0 : cost_a_q;
  assign cm_b = zj0 ? '0 : cost_b_q;

  if (PROD1_W > COST_W) begin : g_sat1
    assign sat1 = (prod1 > PROD1_W'(COST_MAX)) ? SAT1_W'(COST_MAX) : prod1[SAT1_W-1:0];
  end else begin : g_nosat1
    assign sat1 = prod1;
  end

  if (PROD2_W > COST_W) begin : g_sat2
    assign sat2 = (prod2 > PROD2_W'(COST_MAX)) ? COST_MAX : prod2[COST_W-1:0];
  end else begin : g_nosat2
    assign sat2 = COST_W'(prod2);
  end

  assign sum3   = (COST_W+2)'(sat2) + (COST_W+2)'(csum2);
  assign q_next = (sum3 > (COST_W+2)'(COST_MAX)) ? COST_MAX : sum3[COST_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v0   <= 1'b0;
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      have <= 1'b0;
    end else begin
      v0 <= issue;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      if (state == S_LD_A) begin
        have <= 1'b0;
      end else if (v3) begin
        have <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    k0r   <= kc;
    zi0   <= (kc == i0);
    zj0   <= (IDX_W'(kc + 1) == j0);
    k1    <= k0r;
    prod1 <= PROD1_W'(p_a) * PROD1_W'(dim_q);
    csum1 <= (COST_W+1)'(cm_a) + (COST_W+1)'(cm_b);
    k2    <= k1;
    prod2 <= PROD2_W'(sat1) * PROD2_W'(p_b);
    csum2 <= csum1;
    k3    <= k2;
    q3    <= q_next;
    // strict less-than keeps the first split reaching the minimum
    if (v3 && (!have || q3 < best)) begin
      best   <= q3;
      best_k <= k3;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_status || load_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_status) begin
      row        <= '0;
      col        <= '0;
      cost       <= '0;
      split      <= '0;
      status     <= stat_code;
      end_of_run <= 1'b1;
    end else if (load_emit) begin
      row        <= ROW_W'(i0) + ROW_W'(1);
      col        <= ROW_W'(j0) + ROW_W'(1);
      cost       <= diag ? '0 : cost_a_q;
      split      <= diag ? '0 : SPLIT_W'(split_q) + SPLIT_W'(1);
      status     <= STATUS_OK;
      end_of_run <= (i0 == mats0) && (j0 == mats0);
    end
  end

endmodule

### hdl/mco_checker.sv
module mco_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          last,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [mco_pkg::ROW_W-1:0]     row,
  input logic [mco_pkg::ROW_W-1:0]     col,
  input logic [mco_pkg::COST_W-1:0]    cost,
  input logic [mco_pkg::SPLIT_W-1:0]   split,
  input logic [mco_pkg::STATUS_W-1:0]  status,
  input logic                          end_of_run
);
  import mco_pkg::*;

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(row) && $stable(col) &&
      $stable(cost) && $stable(split) && $stable(status) && $stable(end_of_run))
    else $error("result changed while stalled");

  a_no_result_mid_chain: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !last |=> !$rose(out_valid))
    else $error("result raised by a non-final dimension");

  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last |=> !in_ready)
    else $error("input taken while a chain is being solved");

  a_status_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STATUS_OK |->
      end_of_run && row == '0 && col == '0 && cost == '0 && split == '0)
    else $error("malformed status result");

  a_split_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_OK && row != col |->
      SPLIT_W'(split) >= SPLIT_W'(row) && SPLIT_W'(split) < SPLIT_W'(col))
    else $error("split outside its subchain");

endmodule

bind matrix_chain_order_core mco_checker u_mco_checker (.*);
